// ----- design/ogcb_pkg.sv -----
// ----------------------------------------------------------------------------
// ogcb_pkg
// Shared types and constants of the overlapping grid cell binning core.
// ----------------------------------------------------------------------------
package ogcb_pkg;

    localparam int INDEX_W     = 20;
    localparam int ID_W        = 32;
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [2:0] {
        REG_WINDOW_X_MIN   = 3'd0,
        REG_WINDOW_Y_MIN   = 3'd1,
        REG_WINDOW_WIDTH_X = 3'd2,
        REG_WINDOW_WIDTH_Y = 3'd3,
        REG_CELL_WIDTH_X   = 3'd4,
        REG_CELL_WIDTH_Y   = 3'd5,
        REG_GRID_CELLS     = 3'd6,
        REG_CUTOFF         = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic [31:0] window_x_min;
        logic [31:0] window_y_min;
        logic [30:0] window_width_x;
        logic [30:0] window_width_y;
        logic [30:0] cell_width_x;
        logic [30:0] cell_width_y;
        logic [26:0] grid_cells;
        logic [30:0] cutoff_distance;
    } cfg_t;

    typedef struct packed {
        logic has_nbr;
        logic nbr_up;
    } band_t;

    typedef struct packed {
        logic [ID_W-1:0]    point_id;
        logic [INDEX_W-1:0] idx_nn;
        logic [INDEX_W-1:0] idx_nc;
        logic [INDEX_W-1:0] idx_cn;
        logic [INDEX_W-1:0] idx_cc;
        logic               has_x;
        logic               has_y;
    } bin_entry_t;

endpackage

// ----- design/ogcb_axis.sv -----
// ----------------------------------------------------------------------------
// ogcb_axis
// Per-axis cell binning: pipelined restoring divider, count clamp and
// overlap band classification.
// ----------------------------------------------------------------------------
module ogcb_axis
    import ogcb_pkg::*;
#(
    parameter int CW = 11
)
(
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [31:0]   p,
    input  logic signed [31:0]   lo,
    input  logic [30:0]          win_width,
    input  logic [30:0]          cell_width,
    input  logic [CW-1:0]        count,
    input  logic [30:0]          cutoff,
    output logic [CW-1:0]        bin_pos,
    output band_t                band
);

    localparam int RW = 32 + CW;
    localparam int EW = 34 + CW;

    logic [30:0]            d;
    logic signed [31:0]     p0_reg;
    logic signed [32:0]     rel0_reg;

    logic [RW-1:0]          rem_reg  [CW+1];
    logic [CW-1:0]          q_reg    [CW+1];
    logic                   neg_reg  [CW+1];
    logic                   ovf_reg  [CW+1];
    logic signed [31:0]     pd_reg   [CW+1];

    logic [RW-1:0]          rem_next [CW];
    logic [CW-1:0]          q_next   [CW];
    logic [RW-1:0]          dsh      [CW];

    logic [CW-1:0]          k_reg;
    logic [CW-1:0]          k_next;
    logic signed [31:0]     pk_reg;

    logic [CW+30:0]         prod;
    logic signed [EW-1:0]   x1_reg;
    logic [CW-1:0]          kx_reg;
    logic signed [31:0]     px_reg;

    logic signed [EW-1:0]   ps;
    logic signed [EW-1:0]   los;
    logic signed [EW-1:0]   cuts;
    logic signed [EW-1:0]   ds;
    logic signed [EW-1:0]   wws;
    logic signed [EW-1:0]   x2;
    logic                   lower;
    logic                   upper;
    band_t                  band_next;

    logic [CW-1:0]          cell_reg;
    band_t                  band_reg;

    assign d = (cell_width == 31'd0) ? 31'd1 : cell_width;

    always_comb
    begin
        for (int s = 0; s < CW; s++)
        begin
            dsh[s]      = RW'(d) << (CW - 1 - s);
            rem_next[s] = rem_reg[s];
            q_next[s]   = q_reg[s];
            if (rem_reg[s] >= dsh[s])
            begin
                rem_next[s]            = rem_reg[s] - dsh[s];
                q_next[s][CW - 1 - s]  = 1'b1;
            end
        end
    end

    always_comb
    begin
        if (neg_reg[CW])
        begin
            k_next = '0;
        end
        else if (ovf_reg[CW] || (q_reg[CW] >= count))
        begin
            k_next = count - CW'(1);
        end
        else
        begin
            k_next = q_reg[CW];
        end
    end

    assign prod = k_reg * d;

    always_comb
    begin
        ps    = EW'(px_reg);
        los   = EW'(lo);
        cuts  = $signed(EW'(cutoff));
        ds    = $signed(EW'(d));
        wws   = $signed(EW'(win_width));
        x2    = x1_reg + ds;
        lower = (ps > cuts + los) && (ps >= x1_reg) && (ps <= x1_reg + cuts);
        upper = (ps < los + wws - cuts) && (ps >= x2 - cuts) && (ps <= x2);
        band_next.nbr_up = !lower;
        if (lower)
        begin
            band_next.has_nbr = (kx_reg != '0);
        end
        else if (upper)
        begin
            band_next.has_nbr = (kx_reg != count - CW'(1));
        end
        else
        begin
            band_next.has_nbr = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0_reg     <= p;
            rel0_reg   <= 33'(p) - 33'(lo);

            rem_reg[0] <= RW'(rel0_reg[31:0]);
            q_reg[0]   <= '0;
            neg_reg[0] <= rel0_reg[32];
            ovf_reg[0] <= !rel0_reg[32] && (RW'(rel0_reg[31:0]) >= (RW'(d) << CW));
            pd_reg[0]  <= p0_reg;

            for (int s = 0; s < CW; s++)
            begin
                rem_reg[s+1] <= rem_next[s];
                q_reg[s+1]   <= q_next[s];
                neg_reg[s+1] <= neg_reg[s];
                ovf_reg[s+1] <= ovf_reg[s];
                pd_reg[s+1]  <= pd_reg[s];
            end

            k_reg    <= k_next;
            pk_reg   <= pd_reg[CW];

            x1_reg   <= EW'(lo) + $signed(EW'(prod));
            kx_reg   <= k_reg;
            px_reg   <= pk_reg;

            cell_reg <= kx_reg;
            band_reg <= band_next;
        end
    end

    assign bin_pos = cell_reg;
    assign band    = band_reg;

endmodule

// ----- design/ogcb_front.sv -----
// ----------------------------------------------------------------------------
// ogcb_front
// Front end: accepts points, bins both axes and forms the candidate cell
// indices of each point as one queue entry.
// ----------------------------------------------------------------------------
module ogcb_front
    import ogcb_pkg::*;
#(
    parameter int CW = 11
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [ID_W-1:0]     point_id,
    input  logic signed [31:0]  x_coord,
    input  logic signed [31:0]  y_coord,
    input  cfg_t                cfg,
    input  logic [CW-1:0]       sx,
    input  logic [CW-1:0]       sy,
    input  logic                full,
    output logic                entry_valid,
    output bin_entry_t          entry
);

    localparam int NS = CW + 7;

    logic                 en;
    logic                 vld_reg [NS];
    logic [ID_W-1:0]      id_reg  [NS];

    logic [CW-1:0]        colx;
    logic [CW-1:0]        rowy;
    band_t                bx;
    band_t                by;

    logic [CW-1:0]        col_m_reg;
    band_t                bx_m_reg;
    band_t                by_m_reg;
    logic [INDEX_W-1:0]   rowsx_m_reg;

    logic [INDEX_W-1:0]   sx20;
    logic [INDEX_W-1:0]   col20;
    logic [INDEX_W-1:0]   ncol20;
    logic [INDEX_W-1:0]   nrs20;
    bin_entry_t           entry_next;
    bin_entry_t           entry_reg;

    assign en       = !(vld_reg[NS-1] && full);
    assign in_stall = !en;

    ogcb_axis #(.CW(CW)) u_axis_x
    (
        .clk        (clk),
        .en         (en),
        .p          (x_coord),
        .lo         ($signed(cfg.window_x_min)),
        .win_width  (cfg.window_width_x),
        .cell_width (cfg.cell_width_x),
        .count      (sx),
        .cutoff     (cfg.cutoff_distance),
        .bin_pos    (colx),
        .band       (bx)
    );

    ogcb_axis #(.CW(CW)) u_axis_y
    (
        .clk        (clk),
        .en         (en),
        .p          (y_coord),
        .lo         ($signed(cfg.window_y_min)),
        .win_width  (cfg.window_width_y),
        .cell_width (cfg.cell_width_y),
        .count      (sy),
        .cutoff     (cfg.cutoff_distance),
        .bin_pos    (rowy),
        .band       (by)
    );

    always_comb
    begin
        sx20   = INDEX_W'(sx);
        col20  = INDEX_W'(col_m_reg);
        ncol20 = bx_m_reg.nbr_up ? col20 + INDEX_W'(1) : col20 - INDEX_W'(1);
        nrs20  = by_m_reg.nbr_up ? rowsx_m_reg + sx20 : rowsx_m_reg - sx20;
        entry_next.point_id = id_reg[NS-2];
        entry_next.idx_nn   = ncol20 + nrs20;
        entry_next.idx_nc   = ncol20 + rowsx_m_reg;
        entry_next.idx_cn   = col20 + nrs20;
        entry_next.idx_cc   = col20 + rowsx_m_reg;
        entry_next.has_x    = bx_m_reg.has_nbr;
        entry_next.has_y    = by_m_reg.has_nbr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NS; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < NS; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            id_reg[0] <= point_id;
            for (int i = 1; i < NS; i++)
            begin
                id_reg[i] <= id_reg[i-1];
            end
            col_m_reg   <= colx;
            bx_m_reg    <= bx;
            by_m_reg    <= by;
            rowsx_m_reg <= INDEX_W'(rowy) * INDEX_W'(sx);
            entry_reg   <= entry_next;
        end
    end

    assign entry_valid = vld_reg[NS-1];
    assign entry       = entry_reg;

endmodule

// ----- design/ogcb_fifo.sv -----
// ----------------------------------------------------------------------------
// ogcb_fifo
// Short queue of binned points between the front end and the emitter.
// ----------------------------------------------------------------------------
module ogcb_fifo
    import ogcb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  bin_entry_t  din,
    input  logic        pop,
    output bin_entry_t  dout,
    output logic        full,
    output logic        empty
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CNW = $clog2(QUEUE_DEPTH + 1);

    bin_entry_t         mem [QUEUE_DEPTH];
    logic [AW-1:0]      wr_ptr_reg;
    logic [AW-1:0]      rd_ptr_reg;
    logic [CNW-1:0]     cnt_reg;
    logic [CNW-1:0]     cnt_next;

    assign full  = (cnt_reg == CNW'(QUEUE_DEPTH));
    assign empty = (cnt_reg == '0);
    assign dout  = mem[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + CNW'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - CNW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + AW'(1);
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= din;
        end
    end

endmodule

// ----- design/ogcb_back.sv -----
// ----------------------------------------------------------------------------
// ogcb_back
// Emitter: walks the cells of the queue head and drives the result
// output register, one cell per transfer.
// ----------------------------------------------------------------------------
module ogcb_back
    import ogcb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  bin_entry_t          head,
    input  logic                empty,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [INDEX_W-1:0]  cell_index,
    output logic [ID_W-1:0]     point_tag,
    output logic                last_cell
);

    logic [1:0]          step_reg;
    logic [1:0]          step_next;
    logic                load;
    logic                is_last;
    logic [INDEX_W-1:0]  sel_index;

    logic                out_valid_reg;
    logic [INDEX_W-1:0]  cell_index_reg;
    logic [ID_W-1:0]     point_tag_reg;
    logic                last_cell_reg;

    assign load = !empty && (!out_valid_reg || !out_stall);
    assign pop  = load && is_last;

    always_comb
    begin
        case ({head.has_x, head.has_y})
            2'b11:
            begin
                is_last = (step_reg == 2'd3);
                case (step_reg)
                    2'd0:    sel_index = head.idx_nn;
                    2'd1:    sel_index = head.idx_nc;
                    2'd2:    sel_index = head.idx_cn;
                    default: sel_index = head.idx_cc;
                endcase
            end
            2'b10:
            begin
                is_last   = (step_reg == 2'd1);
                sel_index = (step_reg == 2'd0) ? head.idx_nc : head.idx_cc;
            end
            2'b01:
            begin
                is_last   = (step_reg == 2'd1);
                sel_index = (step_reg == 2'd0) ? head.idx_cn : head.idx_cc;
            end
            default:
            begin
                is_last   = 1'b1;
                sel_index = head.idx_cc;
            end
        endcase
    end

    always_comb
    begin
        step_next = step_reg;
        if (load)
        begin
            step_next = is_last ? 2'd0 : step_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cell_index_reg <= sel_index;
            point_tag_reg  <= head.point_id;
            last_cell_reg  <= is_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign cell_index = cell_index_reg;
    assign point_tag  = point_tag_reg;
    assign last_cell  = last_cell_reg;

`ifndef SYNTHESIS
    a_step_holds_head: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg != 2'd0) |-> !empty)
        else $error("cell walk in progress without a queue head");

    a_step_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (load && !is_last) |=> (step_reg == 2'($past(step_reg) + 2'd1)))
        else $error("cell walk step did not advance");

    a_point_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !last_cell) |=> out_valid)
        else $error("point results broken off before last cell");

    a_tag_constant: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !last_cell) |=> (point_tag == $past(point_tag)))
        else $error("point tag changed within one point");
`endif

endmodule

// ----- design/overlapping_grid_cell_binning_core.sv -----
// ----------------------------------------------------------------------------
// overlapping_grid_cell_binning_core
// Bins 2D Q16.16 points into a uniform grid with overlap bands and emits
// one (cell, point) pair per cell a point belongs to.
// ----------------------------------------------------------------------------
//  channel   handshake             payload
//  input     in_valid / in_stall   point_id, x_coord, y_coord
//  output    out_valid / out_stall cell_index, point_tag, last_cell
//  config    cfg_write             cfg_index, cfg_data
//
//  A point yields 1, 2 or 4 results, one per emitted cell: the emitter drives
//  one result per cycle while the queue holds a point and out_stall is low.
//  The front end takes a point every cycle until the queue fills. Its
//  depth is set by the one-bit-per-stage divider; the queue and the output
//  register follow it. Reset clears the pipeline valids, the queue and the
//  emitter; the configuration registers return to their defaults. Output
//  stall holds the result register and backs up via the queue into in_stall.
// ----------------------------------------------------------------------------
module overlapping_grid_cell_binning_core
    import ogcb_pkg::*;
#(
    parameter int MAX_CELLS_PER_AXIS = 1024
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [31:0]         point_id,
    input  logic signed [31:0]  x_coord,
    input  logic signed [31:0]  y_coord,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [19:0]         cell_index,
    output logic [31:0]         point_tag,
    output logic                last_cell,
    input  logic                cfg_write,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data
);

    localparam int CW = $clog2(MAX_CELLS_PER_AXIS + 1);

    cfg_t               cfg_reg;
    logic [15:0]        sx_raw;
    logic [15:0]        sy_raw;
    logic [CW-1:0]      sx;
    logic [CW-1:0]      sy;

    logic               entry_valid;
    bin_entry_t         entry;
    bin_entry_t         head;
    logic               full;
    logic               empty;
    logic               push;
    logic               pop;

    assign sx_raw = cfg_reg.grid_cells[15:0];
    assign sy_raw = {5'd0, cfg_reg.grid_cells[26:16]};

    always_comb
    begin
        if (sx_raw == 16'd0)
        begin
            sx = CW'(1);
        end
        else if (32'(sx_raw) > MAX_CELLS_PER_AXIS)
        begin
            sx = CW'(MAX_CELLS_PER_AXIS);
        end
        else
        begin
            sx = CW'(sx_raw);
        end

        if (sy_raw == 16'd0)
        begin
            sy = CW'(1);
        end
        else if (32'(sy_raw) > MAX_CELLS_PER_AXIS)
        begin
            sy = CW'(MAX_CELLS_PER_AXIS);
        end
        else
        begin
            sy = CW'(sy_raw);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_x_min    <= 32'd0;
            cfg_reg.window_y_min    <= 32'd0;
            cfg_reg.window_width_x  <= 31'd65536;
            cfg_reg.window_width_y  <= 31'd65536;
            cfg_reg.cell_width_x    <= 31'd65536;
            cfg_reg.cell_width_y    <= 31'd65536;
            cfg_reg.grid_cells      <= 27'd65537;
            cfg_reg.cutoff_distance <= 31'd0;
        end
        else if (cfg_write)
        begin
            case (cfg_index_t'(cfg_index))
                REG_WINDOW_X_MIN:   cfg_reg.window_x_min    <= cfg_data;
                REG_WINDOW_Y_MIN:   cfg_reg.window_y_min    <= cfg_data;
                REG_WINDOW_WIDTH_X: cfg_reg.window_width_x  <= cfg_data[30:0];
                REG_WINDOW_WIDTH_Y: cfg_reg.window_width_y  <= cfg_data[30:0];
                REG_CELL_WIDTH_X:   cfg_reg.cell_width_x    <= cfg_data[30:0];
                REG_CELL_WIDTH_Y:   cfg_reg.cell_width_y    <= cfg_data[30:0];
                REG_GRID_CELLS:     cfg_reg.grid_cells      <= cfg_data[26:0];
                REG_CUTOFF:         cfg_reg.cutoff_distance <= cfg_data[30:0];
                default:            cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    ogcb_front #(.CW(CW)) u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .point_id    (point_id),
        .x_coord     (x_coord),
        .y_coord     (y_coord),
        .cfg         (cfg_reg),
        .sx          (sx),
        .sy          (sy),
        .full        (full),
        .entry_valid (entry_valid),
        .entry       (entry)
    );

    assign push = entry_valid && !full;

    ogcb_fifo u_fifo
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (entry),
        .pop   (pop),
        .dout  (head),
        .full  (full),
        .empty (empty)
    );

    ogcb_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .empty      (empty),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .cell_index (cell_index),
        .point_tag  (point_tag),
        .last_cell  (last_cell)
    );

endmodule

// ----- test/overlapping_grid_cell_binning_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// overlapping_grid_cell_binning_core_test
// Drives points into the binning core and checks every emitted (cell, point)
// pair against an in-bench prediction of the grid cells and overlap bands.
// A directed set covers reset values, band corners, window edges, off-grid
// neighbours, zero cell width and out-of-range cell counts. Random and extreme grids then
// run under three stall regimes, with one long output hold-off.
// ----------------------------------------------------------------------------
module overlapping_grid_cell_binning_core_test
    import ogcb_pkg::*;
();

    localparam int MAX_CELLS       = 1024;
    localparam int ONE             = 65536;
    localparam int HOLD_OFF_CYCLES = 150;
    localparam int WATCHDOG_LIMIT  = 2000;

    typedef struct {
        logic [31:0] id;
        logic [31:0] x;
        logic [31:0] y;
    } point_t;

    typedef struct {
        logic [19:0] idx;
        logic [31:0] tag;
        logic        last;
    } cell_hit_t;

    logic        clk;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic        in_stall;
    logic [31:0] point_id   = '0;
    logic [31:0] x_coord    = '0;
    logic [31:0] y_coord    = '0;
    logic        out_valid;
    logic        out_stall  = 1'b0;
    logic [19:0] cell_index;
    logic [31:0] point_tag;
    logic        last_cell;
    logic        cfg_write  = 1'b0;
    logic [2:0]  cfg_index  = REG_WINDOW_X_MIN;
    logic [31:0] cfg_data   = '0;

    // grid settings as the block holds them
    longint lo_x      = 0;
    longint lo_y      = 0;
    longint span_x    = ONE;
    longint span_y    = ONE;
    longint step_x    = ONE;
    longint step_y    = ONE;
    longint grid_word = 65537;
    longint band      = 0;

    logic [31:0] reg_image [8];
    point_t      points_waiting [$];
    cell_hit_t   cells_due [$];
    point_t      offer;

    bit point_moved   = 1'b0;
    bit hold_off_req  = 1'b0;
    int hold_off_left = 0;
    int send_gap_pct  = 0;
    int recv_gap_pct  = 0;
    int quiet_cycles  = 0;
    int mismatch_count = 0;
    int points_binned  = 0;
    int cells_checked  = 0;
    int split_two      = 0;
    int split_four     = 0;
    int grids_loaded   = 0;

    overlapping_grid_cell_binning_core #(
        .MAX_CELLS_PER_AXIS(MAX_CELLS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .point_id(point_id),
        .x_coord(x_coord),
        .y_coord(y_coord),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .cell_index(cell_index),
        .point_tag(point_tag),
        .last_cell(last_cell),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic longint axis_count(input longint n);
        if (n == 0)
            return 1;
        if (n > MAX_CELLS)
            return MAX_CELLS;
        return n;
    endfunction

    function automatic void place_on_axis(input longint p, lo, span, step, count, cut,
                                          output longint slot, output int side);
        longint rel, d, k, x1, x2;
        int     f;
        rel = p - lo;
        d = (step == 0) ? 1 : step;
        f = 0;
        if (rel < 0)
            k = 0;
        else
        begin
            k = rel / d;
            if (k >= count)
                k = count - 1;
        end
        x1 = lo + k * d;
        x2 = x1 + d;
        if (p > cut + lo && p >= x1 && p <= x1 + cut)
            f = -1;
        else if (p < lo + span - cut && p >= x2 - cut && p <= x2)
            f = 1;
        if (k + f < 0 || k + f >= count)
            f = 0;
        slot = k;
        side = f;
    endfunction

    function automatic void bin_point(input logic [31:0] id, x, y);
        longint    sx, sy, col, row;
        longint    cols [2];
        longint    rows [2];
        int        fx, fy, ncol, nrow;
        cell_hit_t hit;
        sx = axis_count(grid_word & 'hFFFF);
        sy = axis_count((grid_word >> 16) & 'h7FF);
        place_on_axis(longint'($signed(x)), lo_x, span_x, step_x, sx, band, col, fx);
        place_on_axis(longint'($signed(y)), lo_y, span_y, step_y, sy, band, row, fy);
        ncol = 0;
        if (fx != 0)
        begin
            cols[ncol] = col + fx;
            ncol++;
        end
        cols[ncol] = col;
        ncol++;
        nrow = 0;
        if (fy != 0)
        begin
            rows[nrow] = row + fy;
            nrow++;
        end
        rows[nrow] = row;
        nrow++;
        for (int i = 0; i < ncol; i++)
        begin
            for (int j = 0; j < nrow; j++)
            begin
                hit.idx  = 20'(cols[i] + rows[j] * sx);
                hit.tag  = id;
                hit.last = (i == ncol - 1 && j == nrow - 1);
                cells_due.insert(cells_due.size(), hit);
            end
        end
        points_binned++;
        if (ncol * nrow == 2)
            split_two++;
        if (ncol * nrow == 4)
            split_four++;
    endfunction

    function automatic logic [31:0] pick_coord(input longint lo, span, step, count, cut);
        longint d, k, s, b;
        d = (step == 0) ? 1 : step;
        s = (cut + 2 > (1 << 20)) ? (1 << 20) : cut + 2;
        case ($urandom_range(9))
            0, 1, 2: b = $urandom;
            3:       b = lo + span;
            default:
            begin
                k = longint'($urandom_range(0, 32'(count + 1))) - 1;
                b = lo + k * d + longint'($urandom_range(0, 32'(2 * s))) - s;
            end
        endcase
        return b[31:0];
    endfunction

    task automatic queue_point(input logic [31:0] id, x, y);
        point_t p;
        p.id = id;
        p.x  = x;
        p.y  = y;
        points_waiting.insert(points_waiting.size(), p);
    endtask

    task automatic load_grid();
        cfg_index_t r;
        r = REG_WINDOW_X_MIN;
        do
        begin
            @(negedge clk);
            cfg_write <= 1'b1;
            cfg_index <= r;
            cfg_data  <= reg_image[r];
            case (r)
                REG_WINDOW_X_MIN:   lo_x      = longint'($signed(reg_image[r]));
                REG_WINDOW_Y_MIN:   lo_y      = longint'($signed(reg_image[r]));
                REG_WINDOW_WIDTH_X: span_x    = reg_image[r][30:0];
                REG_WINDOW_WIDTH_Y: span_y    = reg_image[r][30:0];
                REG_CELL_WIDTH_X:   step_x    = reg_image[r][30:0];
                REG_CELL_WIDTH_Y:   step_y    = reg_image[r][30:0];
                REG_GRID_CELLS:     grid_word = reg_image[r][26:0];
                REG_CUTOFF:         band      = reg_image[r][30:0];
                default:            ;
            endcase
            r = r.next();
        end
        while (r != REG_WINDOW_X_MIN);
        @(negedge clk);
        cfg_write <= 1'b0;
        grids_loaded++;
    endtask

    task automatic draw_grid(input int kind);
        longint sx, sy, dx, dy, wx, wy;
        if (kind == 1)
        begin
            reg_image[REG_WINDOW_X_MIN]   = 32'h8000_0000;
            reg_image[REG_WINDOW_Y_MIN]   = 32'h8000_0000;
            reg_image[REG_WINDOW_WIDTH_X] = 32'h7FFF_FFFF;
            reg_image[REG_WINDOW_WIDTH_Y] = 32'h7FFF_FFFF;
            reg_image[REG_CELL_WIDTH_X]   = 32'h7FFF_FFFF;
            reg_image[REG_CELL_WIDTH_Y]   = 32'h7FFF_FFFF;
            reg_image[REG_GRID_CELLS]     = 32'h0002_0002;
            reg_image[REG_CUTOFF]         = 32'h7FFF_FFFF;
        end
        else if (kind == 2)
        begin
            reg_image[REG_WINDOW_X_MIN]   = 32'h7FFF_FFFF;
            reg_image[REG_WINDOW_Y_MIN]   = 32'h7FFF_FFFF;
            reg_image[REG_WINDOW_WIDTH_X] = 32'h8000_0001;
            reg_image[REG_WINDOW_WIDTH_Y] = 32'h0000_0001;
            reg_image[REG_CELL_WIDTH_X]   = 32'h0000_0001;
            reg_image[REG_CELL_WIDTH_Y]   = 32'h8000_0001;
            reg_image[REG_GRID_CELLS]     = 32'h0400_0400;
            reg_image[REG_CUTOFF]         = 32'h8000_0000;
        end
        else
        begin
            sx = $urandom_range(1, 12);
            sy = $urandom_range(1, 12);
            dx = ($urandom_range(3) == 0) ? $urandom_range(1, 16) : $urandom_range(256, 1 << 18);
            dy = ($urandom_range(3) == 0) ? $urandom_range(1, 16) : $urandom_range(256, 1 << 18);
            wx = ($urandom_range(3) == 0) ? $urandom_range(1, 32'h7FFF_FFFF) : dx * sx;
            wy = ($urandom_range(3) == 0) ? $urandom_range(1, 32'h7FFF_FFFF) : dy * sy;
            reg_image[REG_WINDOW_X_MIN] =
                32'(longint'($urandom_range(0, 1 << 25)) - (1 << 24));
            reg_image[REG_WINDOW_Y_MIN] =
                32'(longint'($urandom_range(0, 1 << 25)) - (1 << 24));
            reg_image[REG_WINDOW_WIDTH_X] = {1'($urandom), 31'(wx)};
            reg_image[REG_WINDOW_WIDTH_Y] = {1'($urandom), 31'(wy)};
            reg_image[REG_CELL_WIDTH_X]   = {1'($urandom), 31'(dx)};
            reg_image[REG_CELL_WIDTH_Y]   = {1'($urandom), 31'(dy)};
            reg_image[REG_GRID_CELLS]     = {5'($urandom), 11'(sy), 16'(sx)};
            reg_image[REG_CUTOFF]         =
                {1'($urandom), 31'($urandom_range(0, 32'((dx < dy ? dx : dy) / 2)))};
        end
        load_grid();
    endtask

    task automatic wait_drained();
        while (points_waiting.size() != 0 || in_valid || cells_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic run_batch(input int n, input bit hold);
        @(posedge clk);
        repeat (n)
            queue_point($urandom,
                        pick_coord(lo_x, span_x, step_x, axis_count(grid_word & 'hFFFF), band),
                        pick_coord(lo_y, span_y, step_y,
                                   axis_count((grid_word >> 16) & 'h7FF), band));
        if (hold)
        begin
            @(posedge clk);
            hold_off_req = 1'b1;
        end
        wait_drained();
    endtask

    // sender: advance only after a transfer or from idle
    always @(negedge clk)
    begin
        if (rst_n && (point_moved || !in_valid))
        begin
            point_moved = 1'b0;
            if (points_waiting.size() != 0 && $urandom_range(99) >= send_gap_pct)
            begin
                offer = points_waiting.pop_front();
                in_valid <= 1'b1;
                point_id <= offer.id;
                x_coord  <= offer.x;
                y_coord  <= offer.y;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver: random stall, or one long hold-off on request
    always @(negedge clk)
    begin
        if (hold_off_left != 0)
        begin
            hold_off_left--;
            out_stall <= 1'b1;
        end
        else if (hold_off_req)
        begin
            hold_off_req = 1'b0;
            hold_off_left = HOLD_OFF_CYCLES - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_gap_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                bin_point(point_id, x_coord, y_coord);
                point_moved = 1'b1;
            end
            if (out_valid && !out_stall)
            begin
                cells_checked++;
                if (cells_due.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t ns: unexpected transfer cell %0d tag %h last %0d",
                             $time, cell_index, point_tag, last_cell);
                end
                else
                begin
                    cell_hit_t want;
                    want = cells_due.pop_front();
                    if (cell_index !== want.idx)
                    begin
                        mismatch_count++;
                        $display("%0t ns: cell_index expected %0d got %0d",
                                 $time, want.idx, cell_index);
                    end
                    if (point_tag !== want.tag)
                    begin
                        mismatch_count++;
                        $display("%0t ns: point_tag expected %h got %h",
                                 $time, want.tag, point_tag);
                    end
                    if (last_cell !== want.last)
                    begin
                        mismatch_count++;
                        $display("%0t ns: last_cell expected %0d got %0d",
                                 $time, want.last, last_cell);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles == WATCHDOG_LIMIT)
            begin
                $display("%0t ns: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        send_gap_pct = 23;
        recv_gap_pct = 76;
        @(posedge clk);

        // reset grid: one cell, no band
        queue_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        queue_point(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        queue_point(32'h1234_5678, ONE, ONE);
        wait_drained();

        // 8 x 8 grid of unit cells, quarter-cell band
        reg_image[REG_WINDOW_X_MIN]   = 0;
        reg_image[REG_WINDOW_Y_MIN]   = 0;
        reg_image[REG_WINDOW_WIDTH_X] = 8 * ONE;
        reg_image[REG_WINDOW_WIDTH_Y] = 8 * ONE;
        reg_image[REG_CELL_WIDTH_X]   = ONE;
        reg_image[REG_CELL_WIDTH_Y]   = ONE;
        reg_image[REG_GRID_CELLS]     = 32'h0008_0008;
        reg_image[REG_CUTOFF]         = ONE / 4;
        load_grid();
        @(posedge clk);
        queue_point(1, ONE / 2, ONE / 2);
        queue_point(2, 3 * ONE + ONE / 10, 4 * ONE + ONE / 2);
        queue_point(3, 3 * ONE + 9 * ONE / 10, 4 * ONE + ONE / 2);
        queue_point(4, 4 * ONE + ONE / 2, 2 * ONE + ONE / 5);
        queue_point(5, 3 * ONE + ONE / 10, 3 * ONE + 9 * ONE / 10);
        queue_point(6, 4 * ONE, 4 * ONE);
        queue_point(7, 8 * ONE, 8 * ONE);
        queue_point(8, -5 * ONE, -5 * ONE);
        queue_point(9, 100 * ONE, 100 * ONE);
        queue_point(10, ONE / 10, 7 * ONE + 9 * ONE / 10);
        queue_point(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        wait_drained();

        // fewer cells than the window holds: neighbours fall off the grid
        reg_image[REG_GRID_CELLS] = 32'h0004_0004;
        load_grid();
        @(posedge clk);
        queue_point(11, 3 * ONE + 9 * ONE / 10, 3 * ONE + 9 * ONE / 10);
        queue_point(12, 3 * ONE + ONE / 10, ONE + ONE / 2);
        queue_point(13, 6 * ONE, 6 * ONE);
        queue_point(14, 2 * ONE + 9 * ONE / 10, 3 * ONE + ONE / 10);
        wait_drained();

        // zero cell width and zero cell count
        reg_image[REG_CELL_WIDTH_X] = 0;
        reg_image[REG_CELL_WIDTH_Y] = 0;
        reg_image[REG_GRID_CELLS]   = 0;
        reg_image[REG_CUTOFF]       = 0;
        load_grid();
        @(posedge clk);
        queue_point(15, 5 * ONE, 5 * ONE);
        wait_drained();

        // cell counts above the maximum, one-LSB cells
        reg_image[REG_WINDOW_WIDTH_X] = 2000;
        reg_image[REG_WINDOW_WIDTH_Y] = 2000;
        reg_image[REG_GRID_CELLS]     = 32'hFFFF_FFFF;
        reg_image[REG_CUTOFF]         = 3;
        load_grid();
        @(posedge clk);
        queue_point(16, 500, 1023);
        queue_point(17, 2000, 2000);
        queue_point(18, 1, 1);
        wait_drained();

        for (int p = 0; p < 8; p++)
        begin
            if (p < 3)
            begin
                send_gap_pct = 23;
                recv_gap_pct = 76;
            end
            else if (p < 6)
            begin
                send_gap_pct = 76;
                recv_gap_pct = 23;
            end
            else
            begin
                send_gap_pct = 0;
                recv_gap_pct = 0;
            end
            draw_grid(p == 0 ? 1 : (p == 4 ? 2 : 0));
            run_batch(p == 6 ? 60 : 20, p == 6);
        end

        repeat (40) @(posedge clk);
        if (cells_due.size() != 0)
        begin
            mismatch_count += cells_due.size();
            $display("%0t ns: %0d expected cells never arrived", $time, cells_due.size());
        end
        $display("binned %0d points into %0d cells (%0d two-cell, %0d four-cell)",
                 points_binned, cells_checked, split_two, split_four);
        $display("%0d grid setups, three stall regimes, one long output hold-off",
                 grids_loaded);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/ogcb_pkg.sv
design/ogcb_axis.sv
design/ogcb_front.sv
design/ogcb_fifo.sv
design/ogcb_back.sv
design/overlapping_grid_cell_binning_core.sv
test/overlapping_grid_cell_binning_core_test.sv
